/* src/hsn_pkg.sv */
// Package for the heightmap smoothed-normal block.
// Holds grid sizes, address widths, command, status and register codes.
// No dependencies.
package hsn_pkg;
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_LENGTH = 64;
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int ZW    = $clog2(MAX_LENGTH);
	localparam int AW    = XW + ZW;
	localparam int DEPTH = MAX_WIDTH * MAX_LENGTH;
	localparam int DIMW  = 7;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic ST_DONE    = 1'b0;
	localparam logic ST_OUTSIDE = 1'b1;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_LENGTH = 2'd1;

	localparam logic [DIMW-1:0] DIM_W_MAX = DIMW'(MAX_WIDTH);
	localparam logic [DIMW-1:0] DIM_L_MAX = DIMW'(MAX_LENGTH);
endpackage

/* src/heightmap_smoothed_normals_top.sv */
// Top level of the heightmap smoothed-normal block.
// Depends on hsn_pkg and hsn_ram (height store).
//
// Channel   Signals                                            Direction
// command   start, busy (out), command, x_pos, z_pos, height_value   in
// result    done, status, height_out, normal_x/y/z             out
// config    cfg_valid, cfg_ready (out), cfg_index, cfg_data        in
//
// A write or an outside coordinate is handled from idle; the result follows in the next cycle.
// A read walks up to five grid points: five height reads, four quadrant checks, and for each
// existing quadrant two squaring steps (S_SQP, S_SQQ) and three components on the shared
// square-root unit, then one step to the next point, for up to twenty quadrants in all.
// Reset clears control state and sets both grid sizes to 64; heights are undefined.
// The receiver cannot stall: done is high for exactly one cycle per item.
module heightmap_smoothed_normals_top
	import hsn_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               command,
	input  logic [XW-1:0]      x_pos,
	input  logic [ZW-1:0]      z_pos,
	input  logic signed [15:0] height_value,
	output logic               done,
	output logic               status,
	output logic signed [15:0] height_out,
	output logic signed [17:0] normal_x,
	output logic signed [17:0] normal_y,
	output logic signed [17:0] normal_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [DIMW-1:0]    cfg_data
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_FETCH = 10'b0000000010,
		S_QUAD  = 10'b0000000100,
		S_SQP   = 10'b0000001000,
		S_SQQ   = 10'b0000010000,
		S_MAG   = 10'b0000100000,
		S_ITER  = 10'b0001000000,
		S_ACC   = 10'b0010000000,
		S_PNEXT = 10'b0100000000,
		S_FIN   = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [DIMW-1:0] width_q, length_q, w_c, l_c;
	logic [XW-1:0] x_q;
	logic [ZW-1:0] z_q;
	logic [2:0] pt_q, cnt_q, nxt_pt;
	logic [1:0] qd_q, comp_q;
	logic [3:0] j_q;
	logic signed [15:0] hc_q, hu_q, hd_q, hl_q, hr_q, hout_q;
	logic signed [17:0] p_q, q_q, v_sel, mul_op, da, db, dc, dd, qp, qq;
	logic signed [35:0] mul_res;
	logic [34:0] sp_q, s_q, sq;
	logic [63:0] t1_q, t2_q, d_q, trial;
	logic [13:0] f_q, m_val;
	logic [14:0] f_inc;
	logic neg_q, qok, in_grid, accept;
	logic signed [19:0] acc_q [3];
	logic signed [19:0] term, mag20;
	logic [4:0] pt_ex;
	logic [XW-1:0] px;
	logic [ZW-1:0] pz;
	logic up, dn, lf, rt;
	logic [XW-1:0] nx;
	logic [ZW-1:0] nz;
	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [15:0] ram_rdata;
	logic done_q, status_q;
	logic signed [15:0] hout_res_q;
	logic signed [17:0] nx_q, ny_q, nz_q;
	logic signed [19:0] hr_v [3];
	logic all_zero;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W_MAX;
			length_q <= DIM_L_MAX;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_LENGTH: length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Grid sizes clamped to the supported range.
	always_comb begin
		w_c = (width_q == '0) ? DIMW'(1) : ((width_q > DIM_W_MAX) ? DIM_W_MAX : width_q);
		l_c = (length_q == '0) ? DIMW'(1) : ((length_q > DIM_L_MAX) ? DIM_L_MAX : length_q);
	end

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign in_grid = (DIMW'(x_pos) < w_c) && (DIMW'(z_pos) < l_c);

	// Which of the five points (center, left, right, up, down) exist.
	always_comb begin
		pt_ex[0] = 1'b1;
		pt_ex[1] = (x_q != '0);
		pt_ex[2] = (DIMW'(x_q) < w_c - DIMW'(1));
		pt_ex[3] = (z_q != '0);
		pt_ex[4] = (DIMW'(z_q) < l_c - DIMW'(1));
		nxt_pt   = pt_q + 3'd1;
	end

	// Position of the current point and its edge flags.
	always_comb begin
		px = x_q;
		pz = z_q;
		case (pt_q)
			3'd1: px = x_q - XW'(1);
			3'd2: px = x_q + XW'(1);
			3'd3: pz = z_q - ZW'(1);
			3'd4: pz = z_q + ZW'(1);
			default: ;
		endcase
		up = (pz != '0);
		dn = (DIMW'(pz) < l_c - DIMW'(1));
		lf = (px != '0);
		rt = (DIMW'(px) < w_c - DIMW'(1));
	end

	// Height read address for each fetch slot: center, up, down, left, right.
	always_comb begin
		nx = px;
		nz = pz;
		case (cnt_q)
			3'd1: nz = pz - ZW'(1);
			3'd2: nz = pz + ZW'(1);
			3'd3: nx = px - XW'(1);
			3'd4: nx = px + XW'(1);
			default: ;
		endcase
		ram_we   = accept && in_grid && (command == CMD_WRITE);
		ram_addr = ram_we ? {z_pos, x_pos} : {nz, nx};
	end

	hsn_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(height_value),
		.rdata(ram_rdata)
	);

	// Edge differences and the quadrant's cross product (p, 256, q).
	always_comb begin
		da = 18'(hu_q) - 18'(hc_q);
		dc = 18'(hd_q) - 18'(hc_q);
		db = 18'(hl_q) - 18'(hc_q);
		dd = 18'(hr_q) - 18'(hc_q);
		case (qd_q)
			2'd0: begin qp = db;  qq = da;  qok = lf && up; end
			2'd1: begin qp = db;  qq = -dc; qok = lf && dn; end
			2'd2: begin qp = -dd; qq = -dc; qok = rt && dn; end
			default: begin qp = -dd; qq = da; qok = rt && up; end
		endcase
	end

	// Shared squaring multiplier.
	always_comb begin
		case (comp_q)
			2'd0:    v_sel = p_q;
			2'd1:    v_sel = 18'sd256;
			default: v_sel = q_q;
		endcase
		case (state_q)
			S_SQP:   mul_op = p_q;
			S_SQQ:   mul_op = q_q;
			default: mul_op = v_sel;
		endcase
		mul_res = mul_op * mul_op;
		sq      = mul_res[34:0];
		trial   = t1_q + t2_q;
		f_inc   = {1'b0, f_q} + 15'd1;
		m_val   = f_inc[14:1];
		mag20   = (pt_q == 3'd0) ? {5'd0, m_val, 1'b0} : {6'd0, m_val};
		term    = neg_q ? -mag20 : mag20;
	end

	// Final halving with rounding away from zero.
	always_comb begin
		all_zero = (acc_q[0] == '0) && (acc_q[1] == '0) && (acc_q[2] == '0);
		for (int i = 0; i < 3; i++) begin
			if (acc_q[i] >= 0) begin
				hr_v[i] = (acc_q[i] + 20'sd1) >>> 1;
			end else begin
				hr_v[i] = -((-acc_q[i] + 20'sd1) >>> 1);
			end
		end
	end

	// Sequencer and shared square-root datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pt_q    <= '0;
			cnt_q   <= '0;
			qd_q    <= '0;
			comp_q  <= '0;
			j_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && in_grid && (command == CMD_READ)) begin
						state_q <= S_FETCH;
						pt_q    <= '0;
						cnt_q   <= '0;
					end
				end
				S_FETCH: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd5) begin
						state_q <= S_QUAD;
						qd_q    <= '0;
					end
				end
				S_QUAD: begin
					if (qok) begin
						state_q <= S_SQP;
					end else if (qd_q == 2'd3) begin
						state_q <= S_PNEXT;
					end else begin
						qd_q <= qd_q + 2'd1;
					end
				end
				S_SQP: state_q <= S_SQQ;
				S_SQQ: begin
					state_q <= S_MAG;
					comp_q  <= '0;
				end
				S_MAG: begin
					state_q <= S_ITER;
					j_q     <= 4'd13;
				end
				S_ITER: begin
					j_q <= j_q - 4'd1;
					if (j_q == '0) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (comp_q != 2'd2) begin
						comp_q  <= comp_q + 2'd1;
						state_q <= S_MAG;
					end else if (qd_q == 2'd3) begin
						state_q <= S_PNEXT;
					end else begin
						qd_q    <= qd_q + 2'd1;
						state_q <= S_QUAD;
					end
				end
				S_PNEXT: begin
					if (pt_q == 3'd4) begin
						state_q <= S_FIN;
					end else begin
						pt_q <= nxt_pt;
						if (pt_ex[nxt_pt]) begin
							state_q <= S_FETCH;
							cnt_q   <= '0;
						end
					end
				end
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= x_pos;
			z_q <= z_pos;
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= '0;
			end
		end
		if (state_q == S_FETCH && cnt_q != '0) begin
			case (cnt_q)
				3'd1: hc_q <= ram_rdata;
				3'd2: hu_q <= ram_rdata;
				3'd3: hd_q <= ram_rdata;
				3'd4: hl_q <= ram_rdata;
				default: hr_q <= ram_rdata;
			endcase
			if (cnt_q == 3'd1 && pt_q == 3'd0) begin
				hout_q <= ram_rdata;
			end
		end
		if (state_q == S_QUAD) begin
			p_q <= qp;
			q_q <= qq;
		end
		if (state_q == S_SQP) begin
			sp_q <= sq;
		end
		if (state_q == S_SQQ) begin
			s_q <= sp_q + 35'd65536 + sq;
		end
		// Bit-serial floor(sqrt(R / s)) with R = (8192 * |v|)^2.
		if (state_q == S_MAG) begin
			d_q   <= 64'(sq) << 26;
			t1_q  <= '0;
			t2_q  <= 64'(s_q) << 26;
			f_q   <= '0;
			neg_q <= (v_sel < 0);
		end
		if (state_q == S_ITER) begin
			if (trial <= d_q) begin
				d_q  <= d_q - trial;
				t1_q <= (t1_q + (t2_q << 1)) >> 1;
				f_q  <= f_q | (14'd1 << j_q);
			end else begin
				t1_q <= t1_q >> 1;
			end
			t2_q <= t2_q >> 2;
		end
		if (state_q == S_ACC) begin
			acc_q[comp_q] <= acc_q[comp_q] + term;
		end
	end

	// Result registers and strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && (!in_grid || command == CMD_WRITE)) || (state_q == S_FIN);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q   <= in_grid ? ST_DONE : ST_OUTSIDE;
			hout_res_q <= in_grid ? height_value : 16'sd0;
			nx_q <= '0;
			ny_q <= '0;
			nz_q <= '0;
		end else if (state_q == S_FIN) begin
			status_q   <= ST_DONE;
			hout_res_q <= hout_q;
			if (all_zero) begin
				nx_q <= '0;
				ny_q <= 18'sd4096;
				nz_q <= '0;
			end else begin
				nx_q <= hr_v[0][17:0];
				ny_q <= hr_v[1][17:0];
				nz_q <= hr_v[2][17:0];
			end
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign height_out = hout_res_q;
	assign normal_x   = nx_q;
	assign normal_y   = ny_q;
	assign normal_z   = nz_q;

	// A result is never shown while a read is still in progress.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	// A read inside the grid starts the sequencer.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_grid && command == CMD_READ) |=> busy)
		else $error("read did not start");

	// The root search keeps iterating until its last bit.
	a_iter_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER && j_q != '0) |=> (state_q == S_ITER))
		else $error("root search left early");

	// An outside coordinate reports zeros.
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_OUTSIDE) |-> (height_out == 0 && normal_y == 0))
		else $error("outside result not zero");
endmodule

/* src/hsn_ram.sv */
// Generic single-port RAM with registered read data.
// Used for the height store; no package dependency.
module hsn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write or one read per cycle; read data is registered and appears in the next cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
